// ===== rtl/core/lrag_pkg.sv =====
package lrag_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned RING_LENGTH = 17;
    localparam int unsigned LAG_START   = 10;
    localparam int unsigned PTR_W       = $clog2(RING_LENGTH);
    localparam int unsigned FILL_W      = $clog2(2 * RING_LENGTH);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MODCNT_W    = $clog2(WORD_W);

    localparam logic [PTR_W-1:0]  LEAD_INIT = '0;
    localparam logic [PTR_W-1:0]  LAG_INIT  = PTR_W'(LAG_START % RING_LENGTH);
    localparam logic [PTR_W-1:0]  RING_LAST = PTR_W'(RING_LENGTH - 1);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(2 * RING_LENGTH - 1);

    localparam logic [WORD_W-1:0] LCG_MULT  = 32'd2891336453;
    localparam logic [WORD_W-1:0] LCG_INC   = 32'd1;
    localparam int unsigned       ROT_FIRST  = 19;
    localparam int unsigned       ROT_SECOND = 27;

    localparam logic CMD_RESEED = 1'b0;

    typedef enum logic {
        OP_RESEED,
        OP_DRAW
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] modulus;
    } t_job;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } t_mod_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_CALC,
        ST_MOD,
        ST_DONE
    } t_back_state;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                                input int unsigned n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        ring_prev = (p == '0) ? RING_LAST : p - PTR_W'(1);
    endfunction

endpackage

// ===== rtl/core/lrag_front.sv =====
module lrag_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_command,
    input  logic [31:0]            i_seed_value,
    input  logic [31:0]            i_modulus,
    output logic                   o_job_valid,
    output lrag_pkg::t_job         o_job,
    input  logic                   i_job_pop
);
    import lrag_pkg::*;

    t_job              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;
    t_job              in_job;

    // classify the incoming item
    always_comb begin
        in_job.op      = (i_command == CMD_RESEED) ? OP_RESEED : OP_DRAW;
        in_job.seed    = i_seed_value;
        in_job.modulus = i_modulus;
    end

    assign o_ready     = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_queue[r_rd_ptr];
    assign push        = i_valid & o_ready;
    assign pop         = i_job_pop & o_job_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_job;
        end
    end

endmodule

// ===== rtl/core/lrag_mod.sv =====
module lrag_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrag_pkg::t_mod_req i_req,
    output lrag_pkg::t_mod_rsp o_rsp
);
    import lrag_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [MODCNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_dvd;
    logic [WORD_W-1:0]   r_div;
    logic [WORD_W:0]     shifted;
    logic [WORD_W:0]     diff;
    logic                fits;

    // restoring remainder, one dividend bit per cycle
    assign shifted = {r_rem, r_dvd[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MODCNT_W'(1);
                if (r_cnt == MODCNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== rtl/core/lrag_back.sv =====
module lrag_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  lrag_pkg::t_job     i_job,
    output logic               o_job_pop,
    output lrag_pkg::t_mod_req o_mod_req,
    input  lrag_pkg::t_mod_rsp i_mod_rsp,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_random_value,
    output logic [31:0]        o_raw_word,
    output logic               o_zero_bound
);
    import lrag_pkg::*;

    logic [WORD_W-1:0] mem_first  [RING_LENGTH];
    logic [WORD_W-1:0] mem_second [RING_LENGTH];
    logic [RING_LENGTH-1:0] r_vld_first, r_vld_second;

    t_back_state       r_state, n_state;
    logic [PTR_W-1:0]  r_lead, n_lead;
    logic [PTR_W-1:0]  r_lag, n_lag;
    logic [FILL_W-1:0] r_fill_cnt, n_fill_cnt;
    logic [WORD_W-1:0] r_seed, n_seed;
    logic [WORD_W-1:0] r_modulus, n_modulus;
    logic [WORD_W-1:0] r_y, n_y;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic              r_zero, n_zero;
    logic [WORD_W-1:0] r_first_lead, r_first_lag, r_second_lead, r_second_lag;

    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_random, r_out_raw;
    logic              r_out_zero;
    logic              out_load;

    logic              we_first, we_second;
    logic [PTR_W-1:0]  wa_first, wa_second;
    logic [WORD_W-1:0] wd_first, wd_second;
    logic [WORD_W-1:0] lcg_next, calc_y, calc_z;

    assign lcg_next = r_seed * LCG_MULT + LCG_INC;
    assign calc_z   = rotl(r_first_lead, ROT_FIRST) + r_first_lag;
    assign calc_y   = rotl(r_second_lead, ROT_SECOND) + r_second_lag;

    always_comb begin
        n_state     = r_state;
        n_lead      = r_lead;
        n_lag       = r_lag;
        n_fill_cnt  = r_fill_cnt;
        n_seed      = r_seed;
        n_modulus   = r_modulus;
        n_y         = r_y;
        n_rem       = r_rem;
        n_zero      = r_zero;
        o_job_pop   = 1'b0;
        out_load    = 1'b0;
        we_first    = 1'b0;
        we_second   = 1'b0;
        wa_first    = r_lead;
        wa_second   = r_lead;
        wd_first    = calc_y;
        wd_second   = calc_z;
        o_mod_req.start    = 1'b0;
        o_mod_req.dividend = r_y;
        o_mod_req.divisor  = r_modulus;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    if (i_job.op == OP_RESEED) begin
                        n_seed     = i_job.seed;
                        n_fill_cnt = '0;
                        n_state    = ST_FILL;
                    end else begin
                        n_modulus = i_job.modulus;
                        n_state   = ST_READ;
                    end
                end
            end
            ST_FILL: begin
                // even count fills the first word of a pair, odd the second
                n_seed     = lcg_next;
                wa_first   = r_fill_cnt[FILL_W-1:1];
                wa_second  = r_fill_cnt[FILL_W-1:1];
                wd_first   = lcg_next;
                wd_second  = lcg_next;
                we_first   = ~r_fill_cnt[0];
                we_second  = r_fill_cnt[0];
                n_fill_cnt = r_fill_cnt + FILL_W'(1);
                if (r_fill_cnt == FILL_LAST) begin
                    n_lead  = LEAD_INIT;
                    n_lag   = LAG_INIT;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                we_first  = 1'b1;
                we_second = 1'b1;
                n_y       = calc_y;
                n_lead    = ring_prev(r_lead);
                n_lag     = ring_prev(r_lag);
                if (r_modulus == '0) begin
                    n_rem   = calc_y;
                    n_zero  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_zero  = 1'b0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // start is taken on the first cycle here, ignored while busy
                o_mod_req.start = 1'b1;
                if (i_mod_rsp.done) begin
                    o_mod_req.start = 1'b0;
                    n_rem   = i_mod_rsp.remainder;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lead       <= LEAD_INIT;
            r_lag        <= LAG_INIT;
            r_fill_cnt   <= '0;
            r_out_valid  <= 1'b0;
            r_vld_first  <= '0;
            r_vld_second <= '0;
        end else begin
            r_state     <= n_state;
            r_lead      <= n_lead;
            r_lag       <= n_lag;
            r_fill_cnt  <= n_fill_cnt;
            r_out_valid <= n_out_valid;
            if (we_first) begin
                r_vld_first[wa_first] <= 1'b1;
            end
            if (we_second) begin
                r_vld_second[wa_second] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed    <= n_seed;
        r_modulus <= n_modulus;
        r_y       <= n_y;
        r_rem     <= n_rem;
        r_zero    <= n_zero;
        if (out_load) begin
            r_out_random <= r_rem;
            r_out_raw    <= r_y;
            r_out_zero   <= r_zero;
        end
    end

    // buffer pair, written at one address, read at lead and lag
    always_ff @(posedge i_clk) begin
        if (we_first) begin
            mem_first[wa_first] <= wd_first;
        end
        if (we_second) begin
            mem_second[wa_second] <= wd_second;
        end
        if (r_state == ST_READ) begin
            r_first_lead  <= r_vld_first[r_lead]  ? mem_first[r_lead]  : '0;
            r_first_lag   <= r_vld_first[r_lag]   ? mem_first[r_lag]   : '0;
            r_second_lead <= r_vld_second[r_lead] ? mem_second[r_lead] : '0;
            r_second_lag  <= r_vld_second[r_lag]  ? mem_second[r_lag]  : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_random;
    assign o_raw_word     = r_out_raw;
    assign o_zero_bound   = r_out_zero;

endmodule

// ===== rtl/core/lagged_rotate_add_random_generator.sv =====
// Lagged rotate-and-add random generator with 17 word pairs in two small
// buffers. A reseed item (command 0) refills all 34 words from a 32-bit
// linear congruential sequence, one multiply per word: it is taken from the
// queue, then the words are filled in turn; it returns no result. A draw
// item (command 1) is taken from the queue, reads the buffers at the lead
// and lag pointers, rotates, adds and writes back, passes through the
// bit-serial remainder unit (a start, a step per dividend bit and a done)
// and loads the output register once it is free. A modulus of 0 skips the
// remainder unit, returns the raw word and sets o_zero_bound. A two-item
// queue in front of the generator accepts up to two more items while a
// draw is in progress or a result waits in the output register; o_ready
// drops once it is full. The buffers read as zero after reset, so draws
// before the first reseed give 0.
module lagged_rotate_add_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_modulus,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_random_value,
    output logic [31:0] o_raw_word,
    output logic        o_zero_bound
);
    import lrag_pkg::*;

    logic     job_valid;
    t_job     job;
    logic     job_pop;
    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    lrag_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_seed_value (i_seed_value),
        .i_modulus    (i_modulus),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_pop    (job_pop)
    );

    lrag_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    lrag_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (job),
        .o_job_pop      (job_pop),
        .o_mod_req      (mod_req),
        .i_mod_rsp      (mod_rsp),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value),
        .o_raw_word     (o_raw_word),
        .o_zero_bound   (o_zero_bound)
    );

    a_zero_bound_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_bound |-> o_random_value == o_raw_word)
        else $error("zero bound result differs from raw word");

    a_reduced_not_above_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_random_value <= o_raw_word)
        else $error("reduced value exceeds raw word");

    a_out_clear_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== dv/lagged_rotate_add_random_generator_tb.sv =====
`timescale 1ns / 100ps

module lagged_rotate_add_random_generator_tb;

    import lrag_pkg::*;

    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [31:0] random_value;
        logic [31:0] raw_word;
        logic        zero_bound;
    } t_draw_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [31:0] i_seed_value;
    logic [31:0] i_modulus;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_random_value;
    logic [31:0] o_raw_word;
    logic        o_zero_bound;

    // generator state mirrored from the block
    logic [31:0] gen_first [RING_LENGTH];
    logic [31:0] gen_second[RING_LENGTH];
    int          gen_lead;
    int          gen_lag;

    t_draw_result pending_draws[$];
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_requests;

    lagged_rotate_add_random_generator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_seed_value   (i_seed_value),
        .i_modulus      (i_modulus),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value),
        .o_raw_word     (o_raw_word),
        .o_zero_bound   (o_zero_bound)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] rotate_left(input logic [31:0] w, input int n);
        logic [63:0] both;
        both = {w, w} << n;
        return both[63:32];
    endfunction

    function automatic int step_down(input int p);
        return (p == 0) ? RING_LENGTH - 1 : p - 1;
    endfunction

    function automatic void reset_generator();
        for (int i = 0; i < RING_LENGTH; i++) begin
            gen_first[i]  = '0;
            gen_second[i] = '0;
        end
        gen_lead = 0;
        gen_lag  = LAG_START % RING_LENGTH;
    endfunction

    function automatic void reseed_generator(input logic [31:0] seed);
        logic [31:0] s;
        s = seed;
        for (int i = 0; i < RING_LENGTH; i++) begin
            s = s * LCG_MULT + LCG_INC;
            gen_first[i] = s;
            s = s * LCG_MULT + LCG_INC;
            gen_second[i] = s;
        end
        gen_lead = 0;
        gen_lag  = LAG_START % RING_LENGTH;
    endfunction

    function automatic t_draw_result draw_generator(input logic [31:0] bound);
        logic [31:0]  z;
        logic [31:0]  y;
        t_draw_result r;
        z = rotate_left(gen_first[gen_lead], ROT_FIRST) + gen_first[gen_lag];
        y = rotate_left(gen_second[gen_lead], ROT_SECOND) + gen_second[gen_lag];
        // written back swapped
        gen_first[gen_lead]  = y;
        gen_second[gen_lead] = z;
        gen_lead = step_down(gen_lead);
        gen_lag  = step_down(gen_lag);
        r.raw_word     = y;
        r.zero_bound   = (bound == '0);
        r.random_value = (bound == '0) ? y : y % bound;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t ns: %s got 0x%08h, expected 0x%08h", $time, what, got, want);
        errors++;
    endtask

    // checks leaving results, then predicts accepted items
    always @(posedge i_clk) begin
        t_draw_result want;
        if (!i_rst_n) begin
            reset_generator();
        end else begin
            if (o_valid && i_ready) begin
                if (pending_draws.size() == 0) begin
                    report_mismatch("unexpected result, raw_word", o_raw_word, '0);
                end else begin
                    want = pending_draws.pop_front();
                    if (o_random_value !== want.random_value)
                        report_mismatch("random_value", o_random_value, want.random_value);
                    if (o_raw_word !== want.raw_word)
                        report_mismatch("raw_word", o_raw_word, want.raw_word);
                    if (o_zero_bound !== want.zero_bound)
                        report_mismatch("zero_bound", 32'(o_zero_bound),
                                        32'(want.zero_bound));
                end
            end
            if (i_valid && o_ready) begin
                if (t_op'(i_command) == OP_RESEED)
                    reseed_generator(i_seed_value);
                else
                    pending_draws.insert(pending_draws.size(), draw_generator(i_modulus));
            end
        end
    end

    // result side: random stalls plus requested long hold-offs
    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input t_op op, input logic [31:0] seed,
                             input logic [31:0] bound);
        // idle cycle by cycle before offering the item
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= logic'(op);
        i_seed_value <= seed;
        i_modulus    <= bound;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return $urandom_range(1, 16);
            3:       return 32'h1 << $urandom_range(31);
            4:       return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // the buffer is all zero after reset, so these draws give 0
    task automatic test_draw_before_seed();
        send_item(OP_DRAW, $urandom, '0);
        send_item(OP_DRAW, $urandom, 32'd5);
        send_item(OP_DRAW, $urandom, 32'hFFFF_FFFF);
    endtask

    task automatic test_reseed_extremes();
        send_item(OP_RESEED, '0, $urandom);
        send_item(OP_DRAW, 32'hFFFF_FFFF, '0);
        send_item(OP_DRAW, $urandom, $urandom);
        send_item(OP_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_DRAW, '0, '0);
        send_item(OP_DRAW, $urandom, $urandom);
    endtask

    task automatic test_bound_extremes();
        send_item(OP_RESEED, $urandom, '0);
        send_item(OP_DRAW, $urandom, '0);
        send_item(OP_DRAW, $urandom, 32'd1);
        send_item(OP_DRAW, $urandom, 32'd2);
        send_item(OP_DRAW, $urandom, 32'd3);
        send_item(OP_DRAW, $urandom, 32'h8000_0000);
        send_item(OP_DRAW, $urandom, 32'h7FFF_FFFF);
        send_item(OP_DRAW, $urandom, 32'hFFFF_FFFF);
    endtask

    // receiver holds off while items keep coming, so the input side stalls
    task automatic test_backpressure();
        hold_requests++;
        send_item(OP_RESEED, $urandom, $urandom);
        for (int i = 0; i < 24; i++)
            send_item(OP_DRAW, $urandom, pick_modulus());
        wait_for_results();
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++)
            send_item(OP_DRAW, $urandom, pick_modulus());
        wait_for_results();
        for (int i = 0; i < 10; i++)
            send_item(OP_DRAW, $urandom, pick_modulus());
    endtask

    // reseed followed by a run of 1 to 60 draws, so longer runs wrap the ring
    task automatic test_random_traffic(input int n_items);
        int count;
        int run_len;
        count = 0;
        while (count < n_items) begin
            send_item(OP_RESEED, pick_seed(), $urandom);
            count++;
            run_len = $urandom_range(1, 60);
            for (int i = 0; i < run_len && count < n_items; i++) begin
                send_item(OP_DRAW, $urandom, pick_modulus());
                count++;
            end
        end
    endtask

    initial begin
        errors        = 0;
        hold_requests = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = logic'(OP_DRAW);
        i_seed_value  = '0;
        i_modulus     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_draw_before_seed();
        test_reseed_extremes();
        test_bound_extremes();
        test_backpressure();
        test_drain_pause();

        send_idle_pct = 27;
        recv_idle_pct = 58;
        test_random_traffic(410);
        send_idle_pct = 58;
        recv_idle_pct = 27;
        test_random_traffic(410);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(410);

        wait_for_results();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_draws.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
